// ===== design/rc6_pkg.sv =====
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared constants, register indexes and helpers for the RC6 block encryptor.
// ----------------------------------------------------------------------------
package rc6_pkg;

	localparam int ROUNDS_DEF        = 20;
	localparam int MAX_KEY_WORDS_DEF = 8;

	localparam int WORD_W    = 32;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int KW_W      = 4;
	localparam int LG_W      = 5;

	localparam logic [WORD_W-1:0] P32 = 32'hB7E1_5163;
	localparam logic [WORD_W-1:0] Q32 = 32'h9E37_79B9;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORDS    = 3'd4;

	localparam logic [KW_W-1:0] KEY_WORDS_RST = 4'd4;

	typedef enum logic [1:0] {
		KS_INIT,
		KS_MIX,
		KS_ALIGN,
		KS_IDLE
	} ks_state_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
		input logic [LG_W-1:0] n);
		logic [2*WORD_W-1:0] t;
		t = {x, x} << n;
		return t[2*WORD_W-1:WORD_W];
	endfunction

endpackage

// ===== design/rc6_if.sv =====
// ----------------------------------------------------------------------------
// rc6 block channels
// Valid/ready channels for plaintext blocks in and ciphertext blocks out.
// ----------------------------------------------------------------------------
interface rc6_plain_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic [31:0] word_c;
	logic [31:0] word_d;
	modport source (output valid, word_a, word_b, word_c, word_d, input ready);
	modport sink (input valid, word_a, word_b, word_c, word_d, output ready);
endinterface

interface rc6_cipher_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_a;
	logic [31:0] out_b;
	logic [31:0] out_c;
	logic [31:0] out_d;
	modport source (output valid, out_a, out_b, out_c, out_d, input ready);
	modport sink (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface

// ===== design/rc6_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// rc6_block_encrypt
// RC6-32 encryption, one round per pipeline stage, ROUNDS+2 stages deep.
// One block per cycle when unstalled.
// After reset or any key write the schedule runs its init, mix and align
// steps before input is taken.
// Reset clears the key registers to zero and key length to four words.
// ----------------------------------------------------------------------------
module rc6_block_encrypt
	import rc6_pkg::*;
#(
	parameter int ROUNDS        = ROUNDS_DEF,
	parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	rc6_plain_if.sink            plain,
	rc6_cipher_if.source         cipher
);

	localparam int RK   = 2*ROUNDS + 4;
	localparam int LAST = ROUNDS + 1;

	logic              keys_ready;
	logic [WORD_W-1:0] rk [RK];
	logic              adv;

	logic              v_s [LAST+1];
	logic [WORD_W-1:0] a_s [LAST+1];
	logic [WORD_W-1:0] b_s [LAST+1];
	logic [WORD_W-1:0] c_s [LAST+1];
	logic [WORD_W-1:0] d_s [LAST+1];

	rc6_key_expand #(
		.ROUNDS        (ROUNDS),
		.MAX_KEY_WORDS (MAX_KEY_WORDS)
	) u_key (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.keys_ready (keys_ready),
		.round_keys (rk)
	);

	assign adv         = !v_s[LAST] || cipher.ready;
	assign plain.ready = keys_ready && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= plain.valid && plain.ready;
			for (int k = 1; k <= LAST; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s[0] <= plain.word_a;
			b_s[0] <= plain.word_b + rk[0];
			c_s[0] <= plain.word_c;
			d_s[0] <= plain.word_d + rk[1];
		end
	end

	for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
		logic [WORD_W-1:0] t, u, na, nc;
		always_comb begin
			t  = rotl(b_s[r-1] * {b_s[r-1][WORD_W-2:0], 1'b1}, LG_W'(LG_W));
			u  = rotl(d_s[r-1] * {d_s[r-1][WORD_W-2:0], 1'b1}, LG_W'(LG_W));
			na = rotl(a_s[r-1] ^ t, u[LG_W-1:0]) + rk[2*r];
			nc = rotl(c_s[r-1] ^ u, t[LG_W-1:0]) + rk[2*r+1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				a_s[r] <= b_s[r-1];
				b_s[r] <= nc;
				c_s[r] <= d_s[r-1];
				d_s[r] <= na;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s[LAST] <= a_s[ROUNDS] + rk[2*ROUNDS+2];
			b_s[LAST] <= b_s[ROUNDS];
			c_s[LAST] <= c_s[ROUNDS] + rk[2*ROUNDS+3];
			d_s[LAST] <= d_s[ROUNDS];
		end
	end

	assign cipher.valid = v_s[LAST];
	assign cipher.out_a = a_s[LAST];
	assign cipher.out_b = b_s[LAST];
	assign cipher.out_c = c_s[LAST];
	assign cipher.out_d = d_s[LAST];

`ifndef ASSERT_OFF
	a_no_take_unkeyed: assert property (@(posedge clk) disable iff (!arst_n)
		!keys_ready |-> !plain.ready)
		else $error("input taken before key schedule done");
	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		plain.valid && plain.ready |=> v_s[0])
		else $error("accepted block lost at pipeline entry");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LAST] && !cipher.ready |=> v_s[LAST] && $stable(a_s[LAST]))
		else $error("stalled result changed");
`endif

endmodule

// ===== design/rc6_key_expand.sv =====
// ----------------------------------------------------------------------------
// rc6_key_expand
// Key registers and sequential key schedule: one mixing step per cycle,
// round keys held in a circular register line.
// ----------------------------------------------------------------------------
module rc6_key_expand
	import rc6_pkg::*;
#(
	parameter int ROUNDS        = ROUNDS_DEF,
	parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output logic                 keys_ready,
	output logic [WORD_W-1:0]    round_keys [2*ROUNDS+4]
);

	localparam int RK      = 2*ROUNDS + 4;
	localparam int MAXST   = 3*((RK > MAX_KEY_WORDS) ? RK : MAX_KEY_WORDS);
	localparam int STEP_W  = $clog2(MAXST + 1);
	localparam int IDX_W   = $clog2(RK);
	localparam int JW      = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

	logic [CFG_W-1:0]  key_q [4];
	logic [KW_W-1:0]   key_words_q;
	ks_state_t         state_q, state_d;
	logic [STEP_W-1:0] cnt_q;
	logic [IDX_W-1:0]  i_q;
	logic [JW-1:0]     j_q;
	logic [WORD_W-1:0] a_q, b_q, init_q;
	logic [WORD_W-1:0] rk_q [RK];
	logic [WORD_W-1:0] scr_q [MAX_KEY_WORDS];

	logic              cfg_hit;
	logic [KW_W-1:0]   c_eff;
	logic [STEP_W-1:0] steps;
	logic [WORD_W-1:0] na, nb, ab;
	logic [IDX_W-1:0]  i_nxt;
	logic [JW-1:0]     j_nxt;
	logic              last_step;

	assign cfg_hit = cfg_we && (cfg_index <= REG_KEY_WORDS);

	always_comb begin
		if (key_words_q == '0) begin
			c_eff = KW_W'(1);
		end else if (key_words_q > KW_W'(MAX_KEY_WORDS)) begin
			c_eff = KW_W'(MAX_KEY_WORDS);
		end else begin
			c_eff = key_words_q;
		end
		if (int'(c_eff) > RK) begin
			steps = STEP_W'(3*int'(c_eff));
		end else begin
			steps = STEP_W'(3*RK);
		end
	end

	always_comb begin
		na        = rotl(rk_q[0] + a_q + b_q, LG_W'(3));
		ab        = na + b_q;
		nb        = rotl(scr_q[j_q] + ab, ab[LG_W-1:0]);
		i_nxt     = (int'(i_q) == RK-1) ? '0 : i_q + 1'b1;
		j_nxt     = (KW_W'(j_q) + 1'b1 == c_eff) ? '0 : j_q + 1'b1;
		last_step = (cnt_q == steps - 1'b1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			KS_INIT: begin
				if (int'(cnt_q) == RK-1) state_d = KS_MIX;
			end
			KS_MIX: begin
				if (last_step) state_d = (i_nxt == '0) ? KS_IDLE : KS_ALIGN;
			end
			KS_ALIGN: begin
				if (i_nxt == '0) state_d = KS_IDLE;
			end
			KS_IDLE: state_d = KS_IDLE;
			default: state_d = KS_INIT;
		endcase
		if (cfg_hit) state_d = KS_INIT;
	end

	always_comb begin
		case (state_q)
			KS_IDLE: keys_ready = 1'b1;
			default: keys_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) key_q[k] <= '0;
			key_words_q <= KEY_WORDS_RST;
			state_q     <= KS_INIT;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
		end else begin
			if (cfg_we && !cfg_index[CFG_IDX_W-1]) key_q[cfg_index[1:0]] <= cfg_wdata;
			if (cfg_we && cfg_index == REG_KEY_WORDS) key_words_q <= cfg_wdata[KW_W-1:0];
			state_q <= state_d;
			if (cfg_hit || (state_q == KS_INIT && state_d == KS_MIX)) begin
				cnt_q <= '0;
				i_q   <= '0;
				j_q   <= '0;
			end else if (state_q == KS_INIT) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == KS_MIX) begin
				cnt_q <= cnt_q + 1'b1;
				i_q   <= i_nxt;
				j_q   <= j_nxt;
			end else if (state_q == KS_ALIGN) begin
				i_q <= i_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			KS_INIT: begin
				for (int k = 0; k < RK-1; k++) rk_q[k] <= rk_q[k+1];
				rk_q[RK-1] <= (cnt_q == '0) ? P32 : init_q;
				init_q     <= ((cnt_q == '0) ? P32 : init_q) + Q32;
				for (int s = 0; s < MAX_KEY_WORDS; s++) begin
					scr_q[s] <= key_q[(s >> 1) & 3][(s & 1)*WORD_W +: WORD_W];
				end
				a_q <= '0;
				b_q <= '0;
			end
			KS_MIX: begin
				for (int k = 0; k < RK-1; k++) rk_q[k] <= rk_q[k+1];
				rk_q[RK-1] <= na;
				scr_q[j_q] <= nb;
				a_q        <= na;
				b_q        <= nb;
			end
			KS_ALIGN: begin
				for (int k = 0; k < RK-1; k++) rk_q[k] <= rk_q[k+1];
				rk_q[RK-1] <= rk_q[0];
			end
			default: ;
		endcase
	end

	assign round_keys = rk_q;

`ifndef ASSERT_OFF
	a_cfg_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !keys_ready)
		else $error("key schedule ready after key write");
	a_idle_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		keys_ready |-> (i_q == '0))
		else $error("round keys not aligned when ready");
`endif

endmodule

// ===== dv/tb_rc6_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// tb_rc6_block_encrypt
// Self-checking bench for the RC6 encryptor: a queued block driver, a cipher
// monitor and a behavioral cipher with its own key schedule, run across
// several key settings with varied input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_rc6_block_encrypt;
	import rc6_pkg::*;

	localparam int NRK = 2 * ROUNDS_DEF + 4;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	rc6_plain_if plain ();
	rc6_cipher_if cipher ();

	rc6_block_encrypt uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .plain(plain.sink), .cipher(cipher.source)
	);

	always #10 clk = ~clk;

	logic [63:0] key_reg [4];
	logic [3:0] key_len;
	logic keys_valid;
	logic [31:0] sched [NRK];

	block_t pending_blocks[$];
	block_t expected_cipher[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_send = 1'b0;
	bit failed = 1'b0;
	int quiet_cycles = 0;

	function automatic logic [31:0] rol(logic [31:0] x, logic [31:0] amt);
		logic [4:0] n;
		n = amt[4:0];
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	function automatic void build_schedule();
		int c;
		int steps;
		int i;
		int j;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] kw [8];
		c = key_len;
		if (c == 0) c = 1;
		if (c > 8) c = 8;
		for (int s = 0; s < c; s++)
			kw[s] = key_reg[s / 2][(s % 2) * 32 +: 32];
		sched[0] = P32;
		for (int s = 1; s < NRK; s++) sched[s] = sched[s - 1] + Q32;
		steps = 3 * ((c > NRK) ? c : NRK);
		x = 0; y = 0; i = 0; j = 0;
		for (int s = 0; s < steps; s++) begin
			sched[i] = rol(sched[i] + x + y, 3);
			x = sched[i];
			kw[j] = rol(kw[j] + x + y, x + y);
			y = kw[j];
			i = (i + 1 == NRK) ? 0 : i + 1;
			j = (j + 1 == c) ? 0 : j + 1;
		end
		keys_valid = 1'b1;
	endfunction

	function automatic block_t encrypt_block(block_t p);
		logic [31:0] a, b, c, d, t, u, tmp;
		if (!keys_valid) build_schedule();
		a = p.a; b = p.b + sched[0]; c = p.c; d = p.d + sched[1];
		for (int r = 1; r <= ROUNDS_DEF; r++) begin
			t = rol(b * (2 * b + 1), 5);
			u = rol(d * (2 * d + 1), 5);
			a = rol(a ^ t, u) + sched[2 * r];
			c = rol(c ^ u, t) + sched[2 * r + 1];
			tmp = a; a = b; b = c; c = d; d = tmp;
		end
		a += sched[2 * ROUNDS_DEF + 2];
		c += sched[2 * ROUNDS_DEF + 3];
		return '{a: a, b: b, c: c, d: d};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain.valid <= 1'b0;
			plain.word_a <= '0;
			plain.word_b <= '0;
			plain.word_c <= '0;
			plain.word_d <= '0;
		end else begin
			if (plain.valid && plain.ready) begin
				expected_cipher.push_back(encrypt_block('{a: plain.word_a,
					b: plain.word_b, c: plain.word_c, d: plain.word_d}));
				void'(pending_blocks.pop_front());
			end
			if (pending_blocks.size() > 0 && !hold_send &&
					$urandom_range(99) >= send_idle_pct) begin
				plain.valid <= 1'b1;
				plain.word_a <= pending_blocks[0].a;
				plain.word_b <= pending_blocks[0].b;
				plain.word_c <= pending_blocks[0].c;
				plain.word_d <= pending_blocks[0].d;
			end else if (!(plain.valid && !plain.ready)) begin
				plain.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher.ready <= 1'b0;
		end else begin
			if (cipher.valid && cipher.ready) begin
				if (expected_cipher.size() == 0) begin
					$display("%0t: unexpected cipher block %h %h %h %h", $time,
						cipher.out_a, cipher.out_b, cipher.out_c, cipher.out_d);
					failed = 1'b1;
				end else begin
					block_t e;
					e = expected_cipher.pop_front();
					if (cipher.out_a !== e.a) begin
						$display("%0t: out_a expected %h actual %h", $time, e.a, cipher.out_a);
						failed = 1'b1;
					end
					if (cipher.out_b !== e.b) begin
						$display("%0t: out_b expected %h actual %h", $time, e.b, cipher.out_b);
						failed = 1'b1;
					end
					if (cipher.out_c !== e.c) begin
						$display("%0t: out_c expected %h actual %h", $time, e.c, cipher.out_c);
						failed = 1'b1;
					end
					if (cipher.out_d !== e.d) begin
						$display("%0t: out_d expected %h actual %h", $time, e.d, cipher.out_d);
						failed = 1'b1;
					end
				end
			end
			cipher.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((plain.valid && plain.ready) || (cipher.valid && cipher.ready) ||
				(pending_blocks.size() == 0 && expected_cipher.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("** rc6_block_encrypt: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_KEY_WORDS) key_reg[idx[1:0]] = val;
		else if (idx == REG_KEY_WORDS) key_len = val[3:0];
		keys_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_blocks.size() > 0 || expected_cipher.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic block_t rand_block();
		return '{a: $urandom, b: $urandom, c: $urandom, d: $urandom};
	endfunction

	task automatic run_random(int n);
		for (int k = 0; k < n; k++) pending_blocks.push_back(rand_block());
		drain();
	endtask

	initial begin
		for (int k = 0; k < 4; k++) key_reg[k] = '0;
		key_len = KEY_WORDS_RST;
		keys_valid = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero key at reset, extreme plaintexts
		pending_blocks.push_back('{a: 0, b: 0, c: 0, d: 0});
		pending_blocks.push_back('{a: '1, b: '1, c: '1, d: '1});
		pending_blocks.push_back('{a: 32'h1, b: 32'h8000_0000, c: 32'h5555_5555,
			d: 32'haaaa_aaaa});
		for (int k = 0; k < 4; k++) pending_blocks.push_back(rand_block());
		drain();

		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_MID_LOW, '1);
		write_reg(REG_KEY_MID_HIGH, '1);
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_WORDS, 64'd8);
		pending_blocks.push_back('{a: 0, b: 0, c: 0, d: 0});
		pending_blocks.push_back('{a: '1, b: '1, c: '1, d: '1});
		drain();
		write_reg(REG_KEY_WORDS, 64'd0);
		pending_blocks.push_back(rand_block());
		drain();
		write_reg(REG_KEY_WORDS, 64'd15);
		pending_blocks.push_back(rand_block());
		drain();
		write_reg(REG_KEY_WORDS, 64'd1);
		pending_blocks.push_back(rand_block());
		drain();
		write_reg(3'd6, rand64());
		pending_blocks.push_back(rand_block());
		drain();

		send_idle_pct = 9;
		recv_idle_pct = 79;
		for (int ph = 0; ph < 7; ph++) begin
			for (int r = 0; r < 4; r++) write_reg(r[CFG_IDX_W-1:0], rand64());
			write_reg(REG_KEY_WORDS, 64'($urandom_range(15)));
			if (ph == 2) begin
				send_idle_pct = 79;
				recv_idle_pct = 9;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 5) begin
				for (int k = 0; k < 10; k++) pending_blocks.push_back(rand_block());
				while (pending_blocks.size() > 0 && expected_cipher.size() == 0)
					@(posedge clk);
				hold_send = 1'b1;
				while (expected_cipher.size() > 0) @(posedge clk);
				hold_send = 1'b0;
			end
			run_random(95);
		end

		if (!failed)
			$display("** rc6_block_encrypt: PASSED **");
		else
			$display("** rc6_block_encrypt: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
design/rc6_pkg.sv
design/rc6_if.sv
design/rc6_key_expand.sv
design/rc6_block_encrypt.sv
dv/tb_rc6_block_encrypt.sv
